// ===== sv/tcd_pkg.sv =====
// Shared types and constants for the table calendar day arithmetic block.
// No dependencies; every other file imports this package.
package tcd_pkg;

  localparam int MONTHS        = 12;
  localparam int YEAR_W        = 12;
  localparam int MONTH_W       = 4;
  localparam int DAY_W         = 6;
  localparam int OFF_W         = 17;
  localparam int COUNT_W       = 20;
  localparam int STAT_W        = 2;
  localparam int MODE_W        = 2;
  localparam int MLEN_W        = 6;
  localparam int YSUM_W        = 9;
  localparam int YENT_W        = MONTHS + YSUM_W;   // written-month mask and year total
  localparam int LIM_W         = 13;
  localparam int YIU_W         = 8;
  localparam int MAX_MONTH_LEN = 32;
  localparam int MAX_YEAR_DAYS = MONTHS * MAX_MONTH_LEN;
  localparam int YEAR_SPAN     = 4096;
  localparam int CFG_IDX_W     = 1;
  localparam int CFG_DATA_W    = 12;

  // Transaction modes
  localparam logic [MODE_W-1:0] MODE_LOAD  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_SHIFT = 2'd1;
  localparam logic [MODE_W-1:0] MODE_DIFF  = 2'd2;
  localparam logic [MODE_W-1:0] MODE_NONE  = 2'd3;

  // Result status codes
  localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
  localparam logic [STAT_W-1:0] ST_MONTH = 2'd1;
  localparam logic [STAT_W-1:0] ST_DAY   = 2'd2;
  localparam logic [STAT_W-1:0] ST_RANGE = 2'd3;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_BASE_YEAR    = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_YEARS_IN_USE = 1'b1;

  typedef struct packed {
    logic [MODE_W-1:0]       mode;
    logic [YEAR_W-1:0]       start_year;
    logic [MONTH_W-1:0]      start_month;
    logic [DAY_W-1:0]        start_day;
    logic signed [OFF_W-1:0] day_offset;
    logic [YEAR_W-1:0]       other_year;
    logic [MONTH_W-1:0]      other_month;
    logic [DAY_W-1:0]        other_day;
    logic [MLEN_W-1:0]       month_length;
  } tcd_item_t;

  typedef struct packed {
    logic [YEAR_W-1:0]         result_year;
    logic [MONTH_W-1:0]        result_month;
    logic [DAY_W-1:0]          result_day;
    logic signed [COUNT_W-1:0] day_count;
    logic [STAT_W-1:0]         status;
  } tcd_res_t;

endpackage

// ===== sv/tcd_if.sv =====
// Handshake channels of the table calendar day arithmetic block.
// Depends on tcd_pkg for field widths.
interface tcd_in_if import tcd_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [MODE_W-1:0]       mode;
  logic [YEAR_W-1:0]       start_year;
  logic [MONTH_W-1:0]      start_month;
  logic [DAY_W-1:0]        start_day;
  logic signed [OFF_W-1:0] day_offset;
  logic [YEAR_W-1:0]       other_year;
  logic [MONTH_W-1:0]      other_month;
  logic [DAY_W-1:0]        other_day;
  logic [MLEN_W-1:0]       month_length;

  modport source (output valid, mode, start_year, start_month, start_day, day_offset,
                  other_year, other_month, other_day, month_length, input ready);
  modport sink (input valid, mode, start_year, start_month, start_day, day_offset,
                other_year, other_month, other_day, month_length, output ready);
endinterface

interface tcd_out_if import tcd_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic [YEAR_W-1:0]         result_year;
  logic [MONTH_W-1:0]        result_month;
  logic [DAY_W-1:0]          result_day;
  logic signed [COUNT_W-1:0] day_count;
  logic [STAT_W-1:0]         status;

  modport source (output valid, result_year, result_month, result_day, day_count, status,
                  input ready);
  modport sink (input valid, result_year, result_month, result_day, day_count, status,
                output ready);
endinterface

interface tcd_cfg_if import tcd_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== sv/table_calendar_day_arithmetic_core.sv =====
// Table-driven calendar day arithmetic. Load transactions write one month length;
// shift transactions move a date by a signed day count; difference transactions
// count the days between two dates. One transaction is processed at a time; the
// sequencer steps through the year and month memories one word at a time, with a
// read state before each use. The result sits in an output register, so the next
// transaction can be taken while it waits. After reset, a clearing pass zeroes
// the per-year memory before the first transaction.
// Depends on tcd_pkg, tcd_if, tcd_tables and tcd_core.
module table_calendar_day_arithmetic_core import tcd_pkg::*; #(
  parameter int TABLE_YEARS = 128
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  tcd_cfg_if.sink   cfg_i,
  tcd_in_if.sink    in_i,
  tcd_out_if.source out_o
);

  localparam int RW  = (TABLE_YEARS > 1) ? $clog2(TABLE_YEARS) : 1;
  localparam int MAW = $clog2(TABLE_YEARS * MONTHS);

  logic [YEAR_W-1:0] base_q, base_d;
  logic [YIU_W-1:0]  yiu_q, yiu_d;
  logic              out_valid_q, out_valid_d;
  tcd_res_t          out_q, out_d;

  tcd_item_t         item;
  tcd_res_t          res;
  logic              res_valid, res_ready;
  logic              tbl_busy;
  logic [RW-1:0]     year_addr;
  logic              year_we, month_we;
  logic [YENT_W-1:0] year_wdata, year_rdata;
  logic [MAW-1:0]    month_addr;
  logic [MLEN_W-1:0] month_wdata, month_rdata;

  // Configuration registers
  assign cfg_i.ready = 1'b1;
  always_comb begin
    base_d = base_q;
    yiu_d  = yiu_q;
    if (cfg_i.valid) begin
      unique case (cfg_i.index)
        CFG_BASE_YEAR:    base_d = cfg_i.data[YEAR_W-1:0];
        CFG_YEARS_IN_USE: yiu_d  = cfg_i.data[YIU_W-1:0];
        default:          base_d = base_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q <= '0;
      yiu_q  <= YIU_W'(128);
    end else begin
      base_q <= base_d;
      yiu_q  <= yiu_d;
    end
  end

  assign item = '{mode: in_i.mode, start_year: in_i.start_year,
                  start_month: in_i.start_month, start_day: in_i.start_day,
                  day_offset: in_i.day_offset, other_year: in_i.other_year,
                  other_month: in_i.other_month, other_day: in_i.other_day,
                  month_length: in_i.month_length};

  tcd_core #(.TABLE_YEARS(TABLE_YEARS)) u_core (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .base_year_i    (base_q),
    .years_in_use_i (yiu_q),
    .item_valid_i   (in_i.valid),
    .item_i         (item),
    .item_ready_o   (in_i.ready),
    .res_valid_o    (res_valid),
    .res_o          (res),
    .res_ready_i    (res_ready),
    .tbl_busy_i     (tbl_busy),
    .year_addr_o    (year_addr),
    .year_we_o      (year_we),
    .year_wdata_o   (year_wdata),
    .year_rdata_i   (year_rdata),
    .month_addr_o   (month_addr),
    .month_we_o     (month_we),
    .month_wdata_o  (month_wdata),
    .month_rdata_i  (month_rdata)
  );

  tcd_tables #(.TABLE_YEARS(TABLE_YEARS)) u_tables (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .year_addr_i   (year_addr),
    .year_we_i     (year_we),
    .year_wdata_i  (year_wdata),
    .year_rdata_o  (year_rdata),
    .month_addr_i  (month_addr),
    .month_we_i    (month_we),
    .month_wdata_i (month_wdata),
    .month_rdata_o (month_rdata),
    .busy_o        (tbl_busy)
  );

  // Output register
  assign res_ready   = !out_valid_q || out_o.ready;
  assign out_valid_d = res_valid || (out_valid_q && !out_o.ready);
  assign out_d       = (res_valid && res_ready) ? res : out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.result_year  = out_q.result_year;
  assign out_o.result_month = out_q.result_month;
  assign out_o.result_day   = out_q.result_day;
  assign out_o.day_count    = out_q.day_count;
  assign out_o.status       = out_q.status;

endmodule

// ===== sv/tcd_tables.sv =====
// Month length memory and per-year memory (written-month mask plus total).
// Depends on tcd_pkg; clears the year memory after reset, one row a cycle.
module tcd_tables import tcd_pkg::*; #(
  parameter int TABLE_YEARS = 128
) (
  input  logic                                     clk_i,
  input  logic                                     rst_ni,
  input  logic [((TABLE_YEARS > 1) ? $clog2(TABLE_YEARS) : 1)-1:0] year_addr_i,
  input  logic                                     year_we_i,
  input  logic [YENT_W-1:0]                        year_wdata_i,
  output logic [YENT_W-1:0]                        year_rdata_o,
  input  logic [$clog2(TABLE_YEARS*MONTHS)-1:0]    month_addr_i,
  input  logic                                     month_we_i,
  input  logic [MLEN_W-1:0]                        month_wdata_i,
  output logic [MLEN_W-1:0]                        month_rdata_o,
  output logic                                     busy_o
);

  localparam int RW  = (TABLE_YEARS > 1) ? $clog2(TABLE_YEARS) : 1;
  localparam int CW  = $clog2(TABLE_YEARS + 1);
  localparam int MDEPTH = TABLE_YEARS * MONTHS;

  logic [YENT_W-1:0] year_mem [TABLE_YEARS];
  logic [MLEN_W-1:0] month_mem [MDEPTH];
  logic [CW-1:0]     clr_q, clr_d;
  logic [YENT_W-1:0] year_rdata_q;
  logic [MLEN_W-1:0] month_rdata_q;

  assign busy_o = (clr_q != CW'(TABLE_YEARS));
  assign clr_d  = busy_o ? clr_q + 1'b1 : clr_q;

  // Clearing pass counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q <= '0;
    end else begin
      clr_q <= clr_d;
    end
  end

  // Year memory: clear sweep first, then normal writes
  always_ff @(posedge clk_i) begin
    if (busy_o) begin
      year_mem[clr_q[RW-1:0]] <= '0;
    end else if (year_we_i) begin
      year_mem[year_addr_i] <= year_wdata_i;
    end
    year_rdata_q <= year_mem[year_addr_i];
  end

  // Month memory, contents undefined until written
  always_ff @(posedge clk_i) begin
    if (month_we_i) begin
      month_mem[month_addr_i] <= month_wdata_i;
    end
    month_rdata_q <= month_mem[month_addr_i];
  end

  assign year_rdata_o  = year_rdata_q;
  assign month_rdata_o = month_rdata_q;

endmodule

// ===== sv/tcd_core.sv =====
// Sequencer for loads, date checks and day walks over the tables,
// with one shared adder. Depends on tcd_pkg and drives tcd_tables.
module tcd_core import tcd_pkg::*; #(
  parameter int TABLE_YEARS = 128
) (
  input  logic                                     clk_i,
  input  logic                                     rst_ni,
  input  logic [YEAR_W-1:0]                        base_year_i,
  input  logic [YIU_W-1:0]                         years_in_use_i,
  input  logic                                     item_valid_i,
  input  tcd_item_t                                item_i,
  output logic                                     item_ready_o,
  output logic                                     res_valid_o,
  output tcd_res_t                                 res_o,
  input  logic                                     res_ready_i,
  input  logic                                     tbl_busy_i,
  output logic [((TABLE_YEARS > 1) ? $clog2(TABLE_YEARS) : 1)-1:0] year_addr_o,
  output logic                                     year_we_o,
  output logic [YENT_W-1:0]                        year_wdata_o,
  input  logic [YENT_W-1:0]                        year_rdata_i,
  output logic [$clog2(TABLE_YEARS*MONTHS)-1:0]    month_addr_o,
  output logic                                     month_we_o,
  output logic [MLEN_W-1:0]                        month_wdata_o,
  input  logic [MLEN_W-1:0]                        month_rdata_i
);

  localparam int RW    = (TABLE_YEARS > 1) ? $clog2(TABLE_YEARS) : 1;
  localparam int MAW   = $clog2(TABLE_YEARS * MONTHS);
  localparam int POS_W = $clog2(TABLE_YEARS * MAX_YEAR_DAYS + 1);
  localparam int AW    = ((POS_W > OFF_W) ? POS_W : OFF_W) + 2;

  localparam logic [4:0] S_IDLE   = 5'd0;
  localparam logic [4:0] S_CK     = 5'd1;
  localparam logic [4:0] S_LD_RD  = 5'd2;
  localparam logic [4:0] S_LD_WR  = 5'd3;
  localparam logic [4:0] S_CK_RD  = 5'd4;
  localparam logic [4:0] S_CK_LEN = 5'd5;
  localparam logic [4:0] S_PY_RD  = 5'd6;
  localparam logic [4:0] S_PY_ADD = 5'd7;
  localparam logic [4:0] S_PM_RD  = 5'd8;
  localparam logic [4:0] S_PM_ADD = 5'd9;
  localparam logic [4:0] S_NX     = 5'd10;
  localparam logic [4:0] S_TY_RD  = 5'd11;
  localparam logic [4:0] S_TY_USE = 5'd12;
  localparam logic [4:0] S_TM_RD  = 5'd13;
  localparam logic [4:0] S_TM_USE = 5'd14;
  localparam logic [4:0] S_DONE   = 5'd15;

  logic [4:0]           state_q, state_d;
  tcd_item_t            item_q, item_d;
  logic                 date_q, date_d;
  logic [RW-1:0]        row_q, row_d, tr_q, tr_d;
  logic [MONTH_W-1:0]   mo_q, mo_d, tm_q, tm_d;
  logic [MONTHS-1:0]    mask_q, mask_d;
  logic signed [AW-1:0] acc_q, acc_d, p1_q, p1_d;
  tcd_res_t             res_q, res_d;

  logic [YEAR_W-1:0]    cy;
  logic [MONTH_W-1:0]   cm;
  logic [DAY_W-1:0]     cd;
  logic [LIM_W-1:0]     lim, room, row_diff;
  logic                 row_ok;
  logic [MONTHS-1:0]    ymask, msel;
  logic [YSUM_W-1:0]    ysum;
  logic [MLEN_W-1:0]    md, len_sat;
  logic signed [AW-1:0] add_a, add_b, add_sum, cmp_val;
  logic                 ge;
  logic                 accept;

  // Current date under check
  assign cy = date_q ? item_q.other_year  : item_q.start_year;
  assign cm = date_q ? item_q.other_month : item_q.start_month;
  assign cd = date_q ? item_q.other_day   : item_q.start_day;

  // Usable rows: min(years_in_use, table depth, years left before wrap)
  always_comb begin
    room = LIM_W'(YEAR_SPAN) - LIM_W'(base_year_i);
    lim  = LIM_W'(years_in_use_i);
    if (lim > LIM_W'(TABLE_YEARS)) lim = LIM_W'(TABLE_YEARS);
    if (lim > room) lim = room;
  end

  assign row_diff = LIM_W'(cy) - LIM_W'(base_year_i);
  assign row_ok   = (cy >= base_year_i) && (row_diff < lim);

  // Table word views; month lengths count only when marked written
  assign ymask   = year_rdata_i[YENT_W-1 -: MONTHS];
  assign ysum    = year_rdata_i[YSUM_W-1:0];
  assign msel    = ((state_q == S_CK_LEN) || (state_q == S_LD_WR)) ? ymask : mask_q;
  assign md      = msel[mo_q] ? month_rdata_i : '0;
  assign len_sat = (item_q.month_length > MLEN_W'(MAX_MONTH_LEN)) ?
                   MLEN_W'(MAX_MONTH_LEN) : item_q.month_length;

  assign year_addr_o  = row_q;
  assign month_addr_o = MAW'(row_q) * MAW'(MONTHS) + MAW'(mo_q);

  // Shared adder and compare
  always_comb begin
    add_a   = acc_q;
    add_b   = '0;
    cmp_val = '0;
    unique case (state_q)
      S_PY_ADD: add_b = $signed(AW'(ysum));
      S_PM_ADD: add_b = $signed(AW'(md));
      S_TY_USE: begin
        add_b   = -$signed(AW'(ysum));
        cmp_val = $signed(AW'(ysum));
      end
      S_TM_USE: begin
        add_b   = -$signed(AW'(md));
        cmp_val = $signed(AW'(md));
      end
      S_NX: begin
        if (item_q.mode == MODE_DIFF) begin
          add_a = p1_q;
          add_b = -acc_q;
        end else begin
          add_b = AW'($signed(item_q.day_offset));
        end
      end
      default: add_b = '0;
    endcase
  end

  assign add_sum = add_a + add_b;
  assign ge      = (acc_q >= cmp_val);

  assign item_ready_o = (state_q == S_IDLE) && !tbl_busy_i;
  assign accept       = item_valid_i && item_ready_o;
  assign res_valid_o  = (state_q == S_DONE);
  assign res_o        = res_q;

  // Sequencer
  always_comb begin
    state_d       = state_q;
    item_d        = item_q;
    date_d        = date_q;
    row_d         = row_q;
    tr_d          = tr_q;
    mo_d          = mo_q;
    tm_d          = tm_q;
    mask_d        = mask_q;
    acc_d         = acc_q;
    p1_d          = p1_q;
    res_d         = res_q;
    year_we_o     = 1'b0;
    month_we_o    = 1'b0;
    year_wdata_o  = {ymask | (MONTHS'(1) << mo_q),
                     ysum - YSUM_W'(md) + YSUM_W'(len_sat)};
    month_wdata_o = len_sat;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          item_d  = item_i;
          date_d  = 1'b0;
          res_d   = '0;
          state_d = S_CK;
        end
      end
      S_CK: begin
        if (item_q.mode == MODE_NONE) begin
          state_d = S_DONE;
        end else if ((cm == '0) || (cm > MONTH_W'(MONTHS))) begin
          res_d.status = ST_MONTH;
          state_d      = S_DONE;
        end else if (!row_ok) begin
          res_d.status = ST_RANGE;
          state_d      = S_DONE;
        end else begin
          row_d   = row_diff[RW-1:0];
          tr_d    = row_diff[RW-1:0];
          mo_d    = cm - 1'b1;
          tm_d    = cm - 1'b1;
          state_d = (item_q.mode == MODE_LOAD) ? S_LD_RD : S_CK_RD;
        end
      end
      S_LD_RD: state_d = S_LD_WR;
      S_LD_WR: begin
        year_we_o  = 1'b1;
        month_we_o = 1'b1;
        state_d    = S_DONE;
      end
      S_CK_RD: state_d = S_CK_LEN;
      S_CK_LEN: begin
        if ((cd == '0) || (cd > DAY_W'(md))) begin
          res_d.status = ST_DAY;
          state_d      = S_DONE;
        end else begin
          acc_d  = $signed(AW'(cd - 1'b1));
          mask_d = ymask;
          mo_d   = '0;
          row_d  = '0;
          if (tr_q != '0) begin
            state_d = S_PY_RD;
          end else if (tm_q != '0) begin
            state_d = S_PM_RD;
          end else begin
            state_d = S_NX;
          end
        end
      end
      // Sum the totals of the rows before the date
      S_PY_RD: state_d = S_PY_ADD;
      S_PY_ADD: begin
        acc_d = add_sum;
        if (({1'b0, row_q} + 1'b1) == {1'b0, tr_q}) begin
          row_d   = tr_q;
          state_d = (tm_q != '0) ? S_PM_RD : S_NX;
        end else begin
          row_d   = row_q + 1'b1;
          state_d = S_PY_RD;
        end
      end
      // Sum the months before the date within its row
      S_PM_RD: state_d = S_PM_ADD;
      S_PM_ADD: begin
        acc_d   = add_sum;
        mo_d    = mo_q + 1'b1;
        state_d = ((mo_q + 1'b1) == tm_q) ? S_NX : S_PM_RD;
      end
      S_NX: begin
        if ((item_q.mode == MODE_DIFF) && !date_q) begin
          p1_d    = acc_q;
          date_d  = 1'b1;
          state_d = S_CK;
        end else if (item_q.mode == MODE_DIFF) begin
          res_d.day_count = COUNT_W'(add_sum);
          state_d         = S_DONE;
        end else if (add_sum < 0) begin
          res_d.status = ST_RANGE;
          state_d      = S_DONE;
        end else begin
          acc_d   = add_sum;
          row_d   = '0;
          state_d = S_TY_RD;
        end
      end
      // Walk rows to find the shifted date's year
      S_TY_RD: state_d = S_TY_USE;
      S_TY_USE: begin
        if (ge) begin
          if ((LIM_W'(row_q) + 1'b1) < lim) begin
            acc_d   = add_sum;
            row_d   = row_q + 1'b1;
            state_d = S_TY_RD;
          end else begin
            res_d.status = ST_RANGE;
            state_d      = S_DONE;
          end
        end else begin
          mask_d  = ymask;
          mo_d    = '0;
          state_d = S_TM_RD;
        end
      end
      // Walk months inside that row
      S_TM_RD: state_d = S_TM_USE;
      S_TM_USE: begin
        if ((mo_q < MONTH_W'(MONTHS - 1)) && ge) begin
          acc_d   = add_sum;
          mo_d    = mo_q + 1'b1;
          state_d = S_TM_RD;
        end else begin
          res_d.result_year  = YEAR_W'(LIM_W'(base_year_i) + LIM_W'(row_q));
          res_d.result_month = mo_q + 1'b1;
          res_d.result_day   = acc_q[DAY_W-1:0] + 1'b1;
          state_d            = S_DONE;
        end
      end
      S_DONE: begin
        if (res_ready_i) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q <= item_d;
    date_q <= date_d;
    row_q  <= row_d;
    tr_q   <= tr_d;
    mo_q   <= mo_d;
    tm_q   <= tm_d;
    mask_q <= mask_d;
    acc_q  <= acc_d;
    p1_q   <= p1_d;
    res_q  <= res_d;
  end

  // A transaction always starts with the date and load checks
  a_accept_to_check: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (state_q == S_CK))
    else $error("accepted transaction did not enter the check step");

  // No table write while the clearing pass runs
  a_no_write_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (year_we_o || month_we_o) |-> !tbl_busy_i)
    else $error("table write during clearing pass");

  // The prefix row walk stays below the date's row
  a_prefix_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_PY_ADD) |-> (row_q < tr_q))
    else $error("prefix walk passed the target row");

  // Month walk stays inside the twelve months
  a_month_walk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == S_TM_USE) || (state_q == S_PM_ADD)) |-> (mo_q < MONTH_W'(MONTHS)))
    else $error("month walk index out of range");

endmodule
